@@ rtl/core/pkdt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkdt_pkg
// Shared types, bus addresses, register codes and key translation for the
// keyboard/display interface adapter.
// ----------------------------------------------------------------------------
package pkdt_pkg;

  localparam int SCREEN_COLUMNS_DEF = 60;
  localparam int SCREEN_ROWS_DEF    = 36;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_KEY   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  localparam logic [15:0] ADDR_KEY_DATA  = 16'hD010;
  localparam logic [15:0] ADDR_KEY_CTRL  = 16'hD011;
  localparam logic [15:0] ADDR_DISP_DATA = 16'hD012;
  localparam logic [15:0] ADDR_DISP_CTRL = 16'hD013;

  localparam logic [7:0] KEY_DATA_RST   = 8'h80;
  localparam logic [7:0] KBD_CTRL_ARMED = 8'h27;
  localparam logic [7:0] KBD_CTRL_KEY   = 8'hA7;
  localparam logic [7:0] STROBE_BIT     = 8'h80;
  localparam int         DSP_CTRL_EN    = 2;

  localparam logic [7:0] KEY_BACKSPACE  = 8'h08;
  localparam logic [7:0] KEY_RUBOUT     = 8'h5F;
  localparam logic [7:0] KEY_NONE       = 8'hFF;
  localparam logic [6:0] CH_LF          = 7'h0A;
  localparam logic [6:0] CH_CR          = 7'h0D;
  localparam logic [6:0] CH_FOLD_MASK   = 7'h5F;
  localparam logic [6:0] CH_LIMIT       = 7'h60;
  localparam logic [6:0] CH_LOWER_END   = 7'h7B;

  typedef struct packed {
    op_t         op;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  key_code;
    logic        shift_held;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] code;
  } key_t;

  typedef struct packed {
    logic       go;
    logic [6:0] ch;
  } tick_t;

  typedef struct packed {
    logic       cell_write;
    logic [5:0] cell_column;
    logic [5:0] cell_row;
    logic [6:0] cell_char;
    logic       scroll_up;
    logic [5:0] cursor_column;
    logic [5:0] cursor_row;
  } disp_t;

  function automatic logic [7:0] shifted_key(input logic [7:0] k);
    logic [7:0] r;
    r = KEY_NONE;
    unique case (k)
      8'h31:   r = 8'h21;
      8'h32:   r = 8'h22;
      8'h33:   r = 8'h3F;
      8'h34:   r = 8'h24;
      8'h35:   r = 8'h25;
      8'h36:   r = 8'h26;
      8'h37:   r = 8'h2F;
      8'h38:   r = 8'h28;
      8'h39:   r = 8'h29;
      8'h30:   r = 8'h3D;
      8'h2E:   r = 8'h3A;
      8'h2C:   r = 8'h3B;
      8'h3C:   r = 8'h3E;
      8'h2D:   r = 8'h5F;
      8'h2B:   r = 8'h2A;
      8'h23:   r = 8'h27;
      8'h71:   r = 8'h40;
      default: begin
        if (k >= 8'h61 && k <= 8'h7A) begin
          r = k - 8'h20;
        end else begin
          r = KEY_NONE;
        end
      end
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/pkdt_keymap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkdt_keymap
// Key code translation: shift map, backspace, upper-case fold, range check.
// ----------------------------------------------------------------------------
module pkdt_keymap (
  input  logic [7:0]     key_code,
  input  logic           shift_held,
  output pkdt_pkg::key_t key
);

  logic [7:0] k_shift;
  logic [7:0] k_bs;
  logic [6:0] c_raw;
  logic [6:0] c_fold;

  always_comb begin
    k_shift = shift_held ? pkdt_pkg::shifted_key(key_code) : key_code;
    k_bs    = (k_shift == pkdt_pkg::KEY_BACKSPACE) ? pkdt_pkg::KEY_RUBOUT : k_shift;
    c_raw   = k_bs[6:0];
    if (c_raw > pkdt_pkg::CH_LIMIT && c_raw < pkdt_pkg::CH_LOWER_END) begin
      c_fold = c_raw & pkdt_pkg::CH_FOLD_MASK;
    end else begin
      c_fold = c_raw;
    end
    key.valid = (c_fold < pkdt_pkg::CH_LIMIT);
    key.code  = c_fold;
  end

endmodule

@@ rtl/core/pkdt_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkdt_regs
// The four adapter registers: bus decode, key latch and display strobe.
// ----------------------------------------------------------------------------
module pkdt_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  pkdt_pkg::item_t item,
  input  pkdt_pkg::key_t  key,
  output logic [7:0]      rd_data,
  output logic            handled,
  output pkdt_pkg::tick_t tick
);

  logic [7:0] key_data_r, key_data_nxt;
  logic [7:0] key_ctrl_r, key_ctrl_nxt;
  logic [7:0] disp_data_r, disp_data_nxt;
  logic [7:0] disp_ctrl_r, disp_ctrl_nxt;

  always_comb begin
    key_data_nxt  = key_data_r;
    key_ctrl_nxt  = key_ctrl_r;
    disp_data_nxt = disp_data_r;
    disp_ctrl_nxt = disp_ctrl_r;
    rd_data       = '0;
    handled       = 1'b0;
    tick          = '0;
    unique case (item.op)
      pkdt_pkg::OP_READ: begin
        handled = 1'b1;
        priority if (item.address == pkdt_pkg::ADDR_KEY_DATA) begin
          key_ctrl_nxt = pkdt_pkg::KBD_CTRL_ARMED;
          rd_data      = key_data_r;
        end else if (item.address == pkdt_pkg::ADDR_KEY_CTRL) begin
          rd_data = key_ctrl_r;
        end else if (item.address == pkdt_pkg::ADDR_DISP_DATA) begin
          rd_data = disp_data_r;
        end else if (item.address == pkdt_pkg::ADDR_DISP_CTRL) begin
          rd_data = disp_ctrl_r;
        end else begin
          handled = 1'b0;
        end
      end
      pkdt_pkg::OP_WRITE: begin
        handled = 1'b1;
        priority if (item.address == pkdt_pkg::ADDR_KEY_DATA) begin
          key_data_nxt = item.write_data;
        end else if (item.address == pkdt_pkg::ADDR_KEY_CTRL) begin
          key_ctrl_nxt = (key_ctrl_r == 8'h00) ? pkdt_pkg::KBD_CTRL_ARMED : item.write_data;
        end else if (item.address == pkdt_pkg::ADDR_DISP_DATA) begin
          if (disp_ctrl_r[pkdt_pkg::DSP_CTRL_EN]) begin
            disp_data_nxt = item.write_data | pkdt_pkg::STROBE_BIT;
          end
        end else if (item.address == pkdt_pkg::ADDR_DISP_CTRL) begin
          disp_ctrl_nxt = item.write_data;
        end else begin
          handled = 1'b0;
        end
      end
      pkdt_pkg::OP_KEY: begin
        if (key.valid) begin
          key_data_nxt = {1'b1, key.code};
          key_ctrl_nxt = pkdt_pkg::KBD_CTRL_KEY;
        end
      end
      pkdt_pkg::OP_TICK: begin
        if (disp_data_r[7]) begin
          tick.go       = 1'b1;
          tick.ch       = disp_data_r[6:0];
          disp_data_nxt = {1'b0, disp_data_r[6:0]};
        end
      end
      default: begin
        key_data_nxt = key_data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_data_r  <= pkdt_pkg::KEY_DATA_RST;
      key_ctrl_r  <= '0;
      disp_data_r <= '0;
      disp_ctrl_r <= '0;
    end else if (en) begin
      key_data_r  <= key_data_nxt;
      key_ctrl_r  <= key_ctrl_nxt;
      disp_data_r <= disp_data_nxt;
      disp_ctrl_r <= disp_ctrl_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_key_latch: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.op == pkdt_pkg::OP_KEY && key.valid |=>
      key_ctrl_r == pkdt_pkg::KBD_CTRL_KEY && key_data_r[7])
    else $error("key latch did not set keyboard registers");
  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    en && tick.go |=> !disp_data_r[7])
    else $error("display strobe not cleared after tick");
`endif

endmodule

@@ rtl/core/pkdt_cursor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkdt_cursor
// Cursor position, cell write, newline, column wrap and scroll on a tick.
// ----------------------------------------------------------------------------
module pkdt_cursor #(
  parameter int SCREEN_COLUMNS = pkdt_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = pkdt_pkg::SCREEN_ROWS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  pkdt_pkg::tick_t tick,
  output pkdt_pkg::disp_t disp
);

  localparam int COL_W = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W = $clog2(SCREEN_ROWS);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_ROWS - 1);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] line_r, line_nxt;
  logic             adv_line;
  logic [COL_W+5:0] col_cur_ext, col_nxt_ext;
  logic [ROW_W+5:0] line_cur_ext, line_nxt_ext;

  assign col_cur_ext  = {6'd0, col_r};
  assign col_nxt_ext  = {6'd0, col_nxt};
  assign line_cur_ext = {6'd0, line_r};
  assign line_nxt_ext = {6'd0, line_nxt};

  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    adv_line = 1'b0;
    disp     = '0;
    if (tick.go) begin
      if (tick.ch == pkdt_pkg::CH_LF || tick.ch == pkdt_pkg::CH_CR) begin
        col_nxt  = '0;
        adv_line = 1'b1;
      end else begin
        disp.cell_write  = 1'b1;
        disp.cell_column = col_cur_ext[5:0];
        disp.cell_row    = line_cur_ext[5:0];
        disp.cell_char   = (tick.ch > pkdt_pkg::CH_FOLD_MASK) ?
                           (tick.ch & pkdt_pkg::CH_FOLD_MASK) : tick.ch;
        if (col_r == COL_LAST) begin
          col_nxt  = '0;
          adv_line = 1'b1;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      if (adv_line) begin
        if (line_r == ROW_LAST) begin
          disp.scroll_up = 1'b1;
        end else begin
          line_nxt = line_r + ROW_W'(1);
        end
      end
    end
    disp.cursor_column = col_nxt_ext[5:0];
    disp.cursor_row    = line_nxt_ext[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
    end else if (en) begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_LAST)
    else $error("cursor column out of range");
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_r <= ROW_LAST)
    else $error("cursor row out of range");
  a_scroll_last: assert property (@(posedge clk) disable iff (!rst_n)
    en && disp.scroll_up |=> line_r == ROW_LAST)
    else $error("scroll left cursor off the last row");
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    en && !tick.go |=> $stable(col_r) && $stable(line_r))
    else $error("cursor moved without a pending character");
`endif

endmodule

@@ rtl/core/pia_keyboard_display_terminal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_keyboard_display_terminal
// Keyboard/display interface adapter: bus register access, key latch and
// display tick producing cell writes and cursor moves.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake           Beat
// in_      in   in_valid/in_stall   operation, address, write_data, key, shift
// out_     out  out_valid/out_stall read data, handled, cell write, cursor
//
// One beat per clock sustained while out_stall is low. A beat accepted into the input
// register passes the combinational logic into the result register and is then
// offered on out_ until it is taken.
// All adapter and cursor state updates in the cycle a beat leaves the input
// register, so back-to-back beats see each other's effects in order.
// in_stall rises only when the input register is full and the result
// register holds a beat not yet taken. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module pia_keyboard_display_terminal #(
  parameter int SCREEN_COLUMNS = pkdt_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = pkdt_pkg::SCREEN_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_key_code,
  input  logic        in_shift_held,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_handled,
  output logic        out_cell_write,
  output logic [5:0]  out_cell_column,
  output logic [5:0]  out_cell_row,
  output logic [6:0]  out_cell_char,
  output logic        out_scroll_up,
  output logic [5:0]  out_cursor_column,
  output logic [5:0]  out_cursor_row
);

  logic            s1_valid_r;
  pkdt_pkg::item_t s1_item_r;
  logic            s1_adv;
  logic            in_acc;
  logic            out_valid_r;
  logic [7:0]      rd_data_r;
  logic            handled_r;
  pkdt_pkg::disp_t disp_r;

  pkdt_pkg::key_t  key;
  pkdt_pkg::tick_t tick;
  pkdt_pkg::disp_t disp;
  logic [7:0]      rd_data;
  logic            handled;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  pkdt_keymap u_keymap (
    .key_code   (s1_item_r.key_code),
    .shift_held (s1_item_r.shift_held),
    .key        (key)
  );

  pkdt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_adv),
    .item    (s1_item_r),
    .key     (key),
    .rd_data (rd_data),
    .handled (handled),
    .tick    (tick)
  );

  pkdt_cursor #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_cursor (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_adv),
    .tick  (tick),
    .disp  (disp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.op         <= pkdt_pkg::op_t'(in_operation);
      s1_item_r.address    <= in_address;
      s1_item_r.write_data <= in_write_data;
      s1_item_r.key_code   <= in_key_code;
      s1_item_r.shift_held <= in_shift_held;
    end
    if (s1_adv) begin
      rd_data_r <= rd_data;
      handled_r <= handled;
      disp_r    <= disp;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = rd_data_r;
  assign out_handled       = handled_r;
  assign out_cell_write    = disp_r.cell_write;
  assign out_cell_column   = disp_r.cell_column;
  assign out_cell_row      = disp_r.cell_row;
  assign out_cell_char     = disp_r.cell_char;
  assign out_scroll_up     = disp_r.scroll_up;
  assign out_cursor_column = disp_r.cursor_column;
  assign out_cursor_row    = disp_r.cursor_row;

`ifndef NO_ASSERTIONS
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room downstream");
  a_cell_not_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cell_write |-> !out_handled && out_read_data == 8'h00)
    else $error("cell write on a bus beat");
`endif

endmodule
